/* rtl/core/assert_macros.svh */
// Assertion macros shared by the look-at view matrix RTL.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset
`define LAV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every edge, reset included
`define LAV_ASSERT_NR(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/core/lav_pkg.sv */
// Package for the look-at view matrix block: widths, types and register codes.
// No dependencies.
`timescale 1ns / 1ps

package lav_pkg;

    localparam int FRAC_BITS = 16;

    // Normalized vector component, magnitude at most one
    localparam int QW  = FRAC_BITS + 2;
    // Raw operand of a normalization (rotated direction or cross product)
    localparam int CW  = (51 > FRAC_BITS + 35) ? 51 : FRAC_BITS + 35;
    // Components after pre-shift, sum of squares, root
    localparam int AW  = 31;
    localparam int SW  = 64;
    localparam int MW  = 32;
    localparam int SHW = $clog2(CW - AW + 1);
    // Divider numerator and remainder
    localparam int NW  = AW + FRAC_BITS + 1;
    localparam int DW  = MW + FRAC_BITS;
    localparam int NDV = FRAC_BITS + 1;
    // Guard register
    localparam int GW  = 17;

    // Configuration port
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 32;

    localparam logic signed [31:0] ONE = 32'(1) << FRAC_BITS;

    typedef enum logic [CFG_IW-1:0] {
        REG_UP_X,
        REG_UP_Y,
        REG_UP_Z,
        REG_GUARD
    } t_reg;

    typedef enum logic [1:0] {
        COL_X,
        COL_Y,
        COL_Z,
        COL_T
    } t_col;

    typedef logic signed [CW-1:0] t_cv;
    typedef logic signed [QW-1:0] t_q;
    typedef logic signed [31:0]   t_e;

    // Payload that rides alongside a normalization
    typedef struct packed {
        logic [2:0][31:0]   eye;
        logic [2:0][QW-1:0] w;
        logic [2:0][QW-1:0] u;
    } t_side;

endpackage

/* rtl/core/lav_in_if.sv */
// Input channel of the look-at view matrix block: eye, direction, rotation.
// Stand-alone interface, no dependencies.
`timescale 1ns / 1ps

interface lav_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [17:0] rot_cos;
    logic signed [17:0] rot_sin;

    modport source(output valid, eye_x, eye_y, eye_z, dir_x, dir_y, dir_z,
                   rot_cos, rot_sin, input ready);
    modport sink(input valid, eye_x, eye_y, eye_z, dir_x, dir_y, dir_z,
                 rot_cos, rot_sin, output ready);
endinterface

/* rtl/core/lav_out_if.sv */
// Output channel of the look-at view matrix block: one matrix column per beat.
// Stand-alone interface, no dependencies.
`timescale 1ns / 1ps

interface lav_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         column_index;
    logic signed [31:0] elem_row0;
    logic signed [31:0] elem_row1;
    logic signed [31:0] elem_row2;
    logic signed [31:0] elem_row3;
    logic               last_column;

    modport source(output valid, column_index, elem_row0, elem_row1, elem_row2,
                   elem_row3, last_column, input ready);
    modport sink(input valid, column_index, elem_row0, elem_row1, elem_row2,
                 elem_row3, last_column, output ready);
endinterface

/* rtl/core/lav_norm.sv */
// Pipelined 3-vector normalizer: pre-shift, sum of squares, bit-per-stage
// square root, bit-per-stage restoring divide. Depends on lav_pkg.
`timescale 1ns / 1ps

module lav_norm import lav_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  t_cv           i_c [3],
    input  t_side         i_side,
    input  logic [GW-1:0] i_guard,
    output logic          o_valid,
    output t_q            o_q [3],
    output t_side         o_side
);

    // Stage 0: magnitudes and signs
    logic          r0_v;
    logic [CW-1:0] r0_a [3];
    logic          r0_neg [3];
    t_side         r0_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r0_v <= 1'b0;
        else if (i_en) r0_v <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r0_neg[i] <= i_c[i][CW-1];
                r0_a[i]   <= i_c[i][CW-1] ? CW'(-i_c[i]) : CW'(i_c[i]);
            end
            r0_side <= i_side;
        end
    end

    // Stage 1: shift that brings the largest magnitude below 2^31
    logic [CW-1:0]  w_or;
    logic [SHW-1:0] w_sh;

    always_comb begin
        w_or = r0_a[0] | r0_a[1] | r0_a[2];
        w_sh = '0;
        for (int b = AW; b < CW; b++) begin
            if (w_or[b]) w_sh = SHW'(b - AW + 1);
        end
    end

    logic           r1_v;
    logic [SHW-1:0] r1_sh;
    logic [CW-1:0]  r1_a [3];
    logic           r1_neg [3];
    t_side          r1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (i_en) r1_v <= r0_v;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sh   <= w_sh;
            r1_a    <= r0_a;
            r1_neg  <= r0_neg;
            r1_side <= r0_side;
        end
    end

    // Stage 2: apply the shift, truncating
    logic          r2_v;
    logic [AW-1:0] r2_a [3];
    logic          r2_neg [3];
    t_side         r2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (i_en) r2_v <= r1_v;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) r2_a[i] <= AW'(r1_a[i] >> r1_sh);
            r2_neg  <= r1_neg;
            r2_side <= r1_side;
        end
    end

    // Stage 3: squares
    logic            r3_v;
    logic [2*AW-1:0] r3_sq [3];
    logic [AW-1:0]   r3_a [3];
    logic            r3_neg [3];
    t_side           r3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (i_en) r3_v <= r2_v;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) r3_sq[i] <= (2*AW)'(r2_a[i]) * (2*AW)'(r2_a[i]);
            r3_a    <= r2_a;
            r3_neg  <= r2_neg;
            r3_side <= r2_side;
        end
    end

    // Square root pipeline; entry 0 is loaded with the sum of squares
    logic          sq_v    [MW+1];
    logic [SW-1:0] sq_n    [MW+1];
    logic [SW-1:0] sq_r    [MW+1];
    logic [AW-1:0] sq_a    [MW+1][3];
    logic          sq_neg  [MW+1][3];
    t_side         sq_side [MW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) sq_v[0] <= 1'b0;
        else if (i_en) sq_v[0] <= r3_v;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            sq_n[0]    <= SW'(r3_sq[0]) + SW'(r3_sq[1]) + SW'(r3_sq[2]);
            sq_r[0]    <= '0;
            sq_a[0]    <= r3_a;
            sq_neg[0]  <= r3_neg;
            sq_side[0] <= r3_side;
        end
    end

    // One result bit per stage, trial bit walking down by two places
    for (genvar k = 0; k < MW; k++) begin : g_sqrt
        localparam logic [SW-1:0] BIT = SW'(1) << (SW - 2 - 2*k);
        logic [SW-1:0] w_try;
        logic          w_ge;

        assign w_try = sq_r[k] + BIT;
        assign w_ge  = (sq_n[k] >= w_try);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) sq_v[k+1] <= 1'b0;
            else if (i_en) sq_v[k+1] <= sq_v[k];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                sq_n[k+1]    <= w_ge ? sq_n[k] - w_try : sq_n[k];
                sq_r[k+1]    <= w_ge ? (sq_r[k] >> 1) + BIT : sq_r[k] >> 1;
                sq_a[k+1]    <= sq_a[k];
                sq_neg[k+1]  <= sq_neg[k];
                sq_side[k+1] <= sq_side[k];
            end
        end
    end

    // Divisor select (guard on zero) and rounded numerators
    logic [MW-1:0] w_root;
    logic [MW-1:0] w_m;

    always_comb begin
        w_root = sq_r[MW][MW-1:0];
        if (w_root != '0) w_m = w_root;
        else if (i_guard == '0) w_m = MW'(1);
        else w_m = MW'(i_guard);
    end

    logic           dv_v    [NDV+1];
    logic [DW-1:0]  dv_r    [NDV+1][3];
    logic [NDV-1:0] dv_q    [NDV+1][3];
    logic [MW-1:0]  dv_m    [NDV+1];
    logic           dv_neg  [NDV+1][3];
    t_side          dv_side [NDV+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) dv_v[0] <= 1'b0;
        else if (i_en) dv_v[0] <= sq_v[MW];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                dv_r[0][i] <= DW'((NW'(sq_a[MW][i]) << FRAC_BITS) + NW'(w_m >> 1));
                dv_q[0][i] <= '0;
            end
            dv_m[0]    <= w_m;
            dv_neg[0]  <= sq_neg[MW];
            dv_side[0] <= sq_side[MW];
        end
    end

    // Restoring divide, quotient bit j = NDV-1-k at stage k
    for (genvar k = 0; k < NDV; k++) begin : g_div
        localparam int J = NDV - 1 - k;
        logic [DW-1:0] w_d;

        assign w_d = DW'(dv_m[k]) << J;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) dv_v[k+1] <= 1'b0;
            else if (i_en) dv_v[k+1] <= dv_v[k];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    if (dv_r[k][i] >= w_d) begin
                        dv_r[k+1][i]    <= dv_r[k][i] - w_d;
                        dv_q[k+1][i]    <= dv_q[k][i] | (NDV'(1) << J);
                    end else begin
                        dv_r[k+1][i]    <= dv_r[k][i];
                        dv_q[k+1][i]    <= dv_q[k][i];
                    end
                end
                dv_m[k+1]    <= dv_m[k];
                dv_neg[k+1]  <= dv_neg[k];
                dv_side[k+1] <= dv_side[k];
            end
        end
    end

    // Output stage: restore signs
    logic  r_ov;
    t_q    r_oq [3];
    t_side r_oside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (i_en) r_ov <= dv_v[NDV];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_oq[i] <= dv_neg[NDV][i] ? -$signed({1'b0, dv_q[NDV][i]})
                                          : $signed({1'b0, dv_q[NDV][i]});
            end
            r_oside <= dv_side[NDV];
        end
    end

    assign o_valid = r_ov;
    assign o_q     = r_oq;
    assign o_side  = r_oside;

endmodule

/* rtl/core/look_at_view_matrix.sv */
// Path from an accepted input beat to its first column beat: three normalizers of 56 stages
// each plus 12 stages of input, rotate, cross, translate and output registers.
// One matrix leaves per four column beats on the output port; an input beat can enter
// each cycle that stage K is empty or the output register is loading a matrix.
// Reset: synchronous, active low; clears valid bits and loads the register defaults
// (up = +y, guard = 7). No memories, so no start-up sweep.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module look_at_view_matrix import lav_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    lav_in_if.sink            i_item,
    lav_out_if.source         o_col
);

    localparam int PW  = 50;            // 18 x 32 rotation products
    localparam int P1W = 32 + QW;       // up x w and eye . basis products
    localparam int P2W = 2 * QW;        // w x u products
    localparam int SMW = P1W + 2;       // dot product sums
    localparam int QTW = SMW - FRAC_BITS;

    logic w_en;
    logic w_load;

    // Configuration registers
    t_e            r_up [3];
    logic [GW-1:0] r_guard;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up[0] <= '0;
            r_up[1] <= ONE;
            r_up[2] <= '0;
            r_guard <= GW'(7);
        end else if (i_cfg_we) begin
            unique case (t_reg'(i_cfg_idx))
                REG_UP_X:  r_up[0] <= i_cfg_data;
                REG_UP_Y:  r_up[1] <= i_cfg_data;
                REG_UP_Z:  r_up[2] <= i_cfg_data;
                REG_GUARD: r_guard <= i_cfg_data[GW-1:0];
                default: ;
            endcase
        end
    end

    assign i_item.ready = w_en;

    // Stage A: input register
    logic               r_a_v;
    t_e                 r_a_eye [3];
    t_e                 r_a_d [3];
    logic signed [17:0] r_a_cs, r_a_sn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_v <= 1'b0;
        else if (w_en) r_a_v <= i_item.valid;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_eye[0] <= i_item.eye_x;
            r_a_eye[1] <= i_item.eye_y;
            r_a_eye[2] <= i_item.eye_z;
            r_a_d[0]   <= i_item.dir_x;
            r_a_d[1]   <= i_item.dir_y;
            r_a_d[2]   <= i_item.dir_z;
            r_a_cs     <= i_item.rot_cos;
            r_a_sn     <= i_item.rot_sin;
        end
    end

    // Stage B: rotation products
    logic                 r_b_v;
    logic signed [PW-1:0] r_b_cx, r_b_sz, r_b_cz, r_b_sx;
    t_e                   r_b_d1;
    t_e                   r_b_eye [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b_v <= 1'b0;
        else if (w_en) r_b_v <= r_a_v;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_cx  <= PW'(r_a_cs) * PW'(r_a_d[0]);
            r_b_sz  <= PW'(r_a_sn) * PW'(r_a_d[2]);
            r_b_cz  <= PW'(r_a_cs) * PW'(r_a_d[2]);
            r_b_sx  <= PW'(r_a_sn) * PW'(r_a_d[0]);
            r_b_d1  <= r_a_d[1];
            r_b_eye <= r_a_eye;
        end
    end

    // Stage C: rotated direction
    logic  r_c_v;
    t_cv   r_c_rd [3];
    t_side r_c_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c_v <= 1'b0;
        else if (w_en) r_c_v <= r_b_v;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_rd[0]  <= CW'(r_b_cx) + CW'(r_b_sz);
            r_c_rd[1]  <= CW'(r_b_d1) <<< FRAC_BITS;
            r_c_rd[2]  <= CW'(r_b_cz) - CW'(r_b_sx);
            r_c_side.w <= '0;
            r_c_side.u <= '0;
            for (int i = 0; i < 3; i++) r_c_side.eye[i] <= r_b_eye[i];
        end
    end

    // Normalize direction into w
    logic  w_nw_v;
    t_q    w_nw_q [3];
    t_side w_nw_side;

    lav_norm u_norm_w (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_c_v),
        .i_c     (r_c_rd),
        .i_side  (r_c_side),
        .i_guard (r_guard),
        .o_valid (w_nw_v),
        .o_q     (w_nw_q),
        .o_side  (w_nw_side)
    );

    // Stage D: up x w products
    logic                  r_d_v;
    logic signed [P1W-1:0] r_d_p [6];
    t_side                 r_d_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d_v <= 1'b0;
        else if (w_en) r_d_v <= w_nw_v;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_p[0] <= P1W'(r_up[1]) * P1W'(w_nw_q[2]);
            r_d_p[1] <= P1W'(r_up[2]) * P1W'(w_nw_q[1]);
            r_d_p[2] <= P1W'(r_up[2]) * P1W'(w_nw_q[0]);
            r_d_p[3] <= P1W'(r_up[0]) * P1W'(w_nw_q[2]);
            r_d_p[4] <= P1W'(r_up[0]) * P1W'(w_nw_q[1]);
            r_d_p[5] <= P1W'(r_up[1]) * P1W'(w_nw_q[0]);
            r_d_side.eye <= w_nw_side.eye;
            r_d_side.u   <= w_nw_side.u;
            for (int i = 0; i < 3; i++) r_d_side.w[i] <= w_nw_q[i];
        end
    end

    // Stage E: up x w differences
    logic  r_e_v;
    t_cv   r_e_t [3];
    t_side r_e_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_e_v <= 1'b0;
        else if (w_en) r_e_v <= r_d_v;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) r_e_t[i] <= CW'(r_d_p[2*i]) - CW'(r_d_p[2*i+1]);
            r_e_side <= r_d_side;
        end
    end

    // Normalize into u
    logic  w_nu_v;
    t_q    w_nu_q [3];
    t_side w_nu_side;

    lav_norm u_norm_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_e_v),
        .i_c     (r_e_t),
        .i_side  (r_e_side),
        .i_guard (r_guard),
        .o_valid (w_nu_v),
        .o_q     (w_nu_q),
        .o_side  (w_nu_side)
    );

    // Stage F: w x u products
    logic                  r_f_v;
    logic signed [P2W-1:0] r_f_p [6];
    t_side                 r_f_side;
    t_q                    w_w [3];

    always_comb begin
        for (int i = 0; i < 3; i++) w_w[i] = $signed(w_nu_side.w[i]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_f_v <= 1'b0;
        else if (w_en) r_f_v <= w_nu_v;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_p[0] <= P2W'(w_w[1]) * P2W'(w_nu_q[2]);
            r_f_p[1] <= P2W'(w_w[2]) * P2W'(w_nu_q[1]);
            r_f_p[2] <= P2W'(w_w[2]) * P2W'(w_nu_q[0]);
            r_f_p[3] <= P2W'(w_w[0]) * P2W'(w_nu_q[2]);
            r_f_p[4] <= P2W'(w_w[0]) * P2W'(w_nu_q[1]);
            r_f_p[5] <= P2W'(w_w[1]) * P2W'(w_nu_q[0]);
            r_f_side.eye <= w_nu_side.eye;
            r_f_side.w   <= w_nu_side.w;
            for (int i = 0; i < 3; i++) r_f_side.u[i] <= w_nu_q[i];
        end
    end

    // Stage G: w x u differences
    logic  r_g_v;
    t_cv   r_g_t [3];
    t_side r_g_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_g_v <= 1'b0;
        else if (w_en) r_g_v <= r_f_v;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) r_g_t[i] <= CW'(r_f_p[2*i]) - CW'(r_f_p[2*i+1]);
            r_g_side <= r_f_side;
        end
    end

    // Normalize into v
    logic  w_nv_v;
    t_q    w_nv_q [3];
    t_side w_nv_side;

    lav_norm u_norm_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_g_v),
        .i_c     (r_g_t),
        .i_side  (r_g_side),
        .i_guard (r_guard),
        .o_valid (w_nv_v),
        .o_q     (w_nv_q),
        .o_side  (w_nv_side)
    );

    // Stage H: eye . basis products, basis index b = 0 u, 1 v, 2 w
    t_q w_bas [3][3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_bas[0][i] = $signed(w_nv_side.u[i]);
            w_bas[1][i] = w_nv_q[i];
            w_bas[2][i] = $signed(w_nv_side.w[i]);
        end
    end

    logic                  r_h_v;
    logic signed [P1W-1:0] r_h_p [3][3];
    t_q                    r_h_bas [3][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_h_v <= 1'b0;
        else if (w_en) r_h_v <= w_nv_v;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int b = 0; b < 3; b++) begin
                for (int i = 0; i < 3; i++) begin
                    r_h_p[b][i] <= P1W'($signed(w_nv_side.eye[i])) * P1W'(w_bas[b][i]);
                end
            end
            r_h_bas <= w_bas;
        end
    end

    // Stage I: dot product sums
    logic                  r_i_v;
    logic signed [SMW-1:0] r_i_s [3];
    t_q                    r_i_bas [3][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_i_v <= 1'b0;
        else if (w_en) r_i_v <= r_h_v;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int b = 0; b < 3; b++) begin
                r_i_s[b] <= SMW'(r_h_p[b][0]) + SMW'(r_h_p[b][1]) + SMW'(r_h_p[b][2]);
            end
            r_i_bas <= r_h_bas;
        end
    end

    // Stage J: rounded magnitude, ties away from zero
    logic           r_j_v;
    logic [QTW-1:0] r_j_q [3];
    logic           r_j_neg [3];
    t_q             r_j_bas [3][3];
    logic [SMW-1:0] w_abs [3];

    always_comb begin
        for (int b = 0; b < 3; b++) begin
            w_abs[b] = r_i_s[b][SMW-1] ? SMW'(-r_i_s[b]) : SMW'(r_i_s[b]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_j_v <= 1'b0;
        else if (w_en) r_j_v <= r_i_v;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int b = 0; b < 3; b++) begin
                r_j_q[b]   <= QTW'((w_abs[b] + (SMW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
                r_j_neg[b] <= r_i_s[b][SMW-1];
            end
            r_j_bas <= r_i_bas;
        end
    end

    // Stage K: negate and saturate the translation
    localparam logic [QTW-1:0] LIM_POS = QTW'(32'h7fff_ffff);
    localparam logic [QTW-1:0] LIM_NEG = QTW'(33'h1_0000_0000) >> 1;

    logic r_k_v;
    t_e   r_k_t [3];
    t_q   r_k_bas [3][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_k_v <= 1'b0;
        else if (w_en) r_k_v <= r_j_v;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int b = 0; b < 3; b++) begin
                if (r_j_neg[b]) begin
                    r_k_t[b] <= (r_j_q[b] > LIM_POS) ? 32'sh7fff_ffff : 32'(r_j_q[b]);
                end else begin
                    r_k_t[b] <= (r_j_q[b] > LIM_NEG) ? 32'sh8000_0000 : -(32'(r_j_q[b]));
                end
            end
            r_k_bas <= r_j_bas;
        end
    end

    // Output register: one matrix, sent as four column beats
    logic r_ov;
    t_col r_col;
    t_e   r_m_t [3];
    t_q   r_m_bas [3][3];

    assign w_load = !r_ov || (o_col.ready && r_col == COL_T);
    assign w_en   = !r_k_v || w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_col <= COL_X;
        end else if (r_k_v && w_load) begin
            r_ov  <= 1'b1;
            r_col <= COL_X;
        end else if (r_ov && o_col.ready) begin
            if (r_col == COL_T) r_ov <= 1'b0;
            else r_col <= t_col'(r_col + 2'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_k_v && w_load) begin
            r_m_t   <= r_k_t;
            r_m_bas <= r_k_bas;
        end
    end

    // Column select
    always_comb begin
        o_col.valid        = r_ov;
        o_col.column_index = r_col;
        o_col.last_column  = (r_col == COL_T);
        unique case (r_col)
            COL_X, COL_Y, COL_Z: begin
                o_col.elem_row0 = 32'(r_m_bas[0][r_col]);
                o_col.elem_row1 = 32'(r_m_bas[1][r_col]);
                o_col.elem_row2 = 32'(r_m_bas[2][r_col]);
                o_col.elem_row3 = '0;
            end
            COL_T: begin
                o_col.elem_row0 = r_m_t[0];
                o_col.elem_row1 = r_m_t[1];
                o_col.elem_row2 = r_m_t[2];
                o_col.elem_row3 = ONE;
            end
            default: begin
                o_col.elem_row0 = '0;
                o_col.elem_row1 = '0;
                o_col.elem_row2 = '0;
                o_col.elem_row3 = '0;
            end
        endcase
    end

    // Checks
    `LAV_ASSERT(a_col_step, (o_col.valid && o_col.ready && r_col != COL_T) |=> (o_col.valid && r_col == t_col'($past(r_col) + 2'd1)), "column beats out of order")
    `LAV_ASSERT(a_tail_hold, (r_k_v && r_ov && !(o_col.ready && r_col == COL_T)) |-> !w_en, "finished matrix would be dropped")
    `LAV_ASSERT_NR(a_rst_quiet, !i_rst_n |=> !o_col.valid, "output valid after reset")

endmodule

/* test/look_at_view_matrix_tb.sv */
// Testbench for look_at_view_matrix: directed table plus random view setups,
// every column beat checked against the typed rows of the table or an in-bench fixed-point predictor.
// Depends on lav_pkg, lav_in_if, lav_out_if and the look_at_view_matrix RTL.
`timescale 1ns / 1ps

module look_at_view_matrix_tb;
    import lav_pkg::*;

    localparam int             WATCHDOG_LIMIT = 4000;
    localparam int             DRAIN_CYCLES   = 200;
    localparam int             HOLD_CYCLES    = 800;
    localparam logic [CFG_IW-1:0] REG_UNUSED  = 3'd5;
    localparam int             INT_MIN        = 32'h8000_0000;
    localparam int             INT_MAX        = 32'h7fff_ffff;

    typedef longint t_vec [3];

    typedef struct {
        int                 eye [3];
        int                 dir [3];
        logic signed [17:0] rot_cos;
        logic signed [17:0] rot_sin;
    } t_view;

    typedef struct {
        logic [1:0] column_index;
        int         elem [4];
        logic       last_column;
    } t_column;

    typedef struct {
        t_view view;
        bit    typed;
        int    cols [4][4];
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IW-1:0] i_cfg_idx;
    logic [CFG_DW-1:0] i_cfg_data;

    lav_in_if  item_bus ();
    lav_out_if col_bus ();

    look_at_view_matrix dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_bus),
        .o_col      (col_bus)
    );

    // Shadow copy of the configuration registers
    longint          up_vec [3];
    longint unsigned guard_mag;

    t_column column_q [$];
    int      errors;
    int      beats_seen;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------

    function automatic longint unsigned mag_u(longint x);
        return (x < 0) ? longint'(-x) : x;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Unit vector: pre-shift below 2^31, floor root, rounded division
    function automatic t_vec unit_vec(t_vec c);
        longint unsigned a [3];
        longint unsigned mx, sum, m, q;
        int s;
        t_vec r;
        mx = 0;
        sum = 0;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            a[i] = mag_u(c[i]);
            if (a[i] > mx) mx = a[i];
        end
        while ((mx >> s) >= (64'd1 << 31)) s++;
        for (int i = 0; i < 3; i++) begin
            a[i] = a[i] >> s;
            sum += a[i] * a[i];
        end
        m = root_floor(sum);
        if (m == 0) m = (guard_mag != 0) ? guard_mag : 1;
        for (int i = 0; i < 3; i++) begin
            q = ((a[i] << FRAC_BITS) + m / 2) / m;
            r[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
        end
        return r;
    endfunction

    function automatic t_vec cross_vec(t_vec a, t_vec b);
        t_vec r;
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
        return r;
    endfunction

    // Saturated, negated, rounded dot product of eye with a basis vector
    function automatic int translate_term(t_vec e, t_vec b);
        longint s;
        longint unsigned q;
        longint t;
        s = e[0] * b[0] + e[1] * b[1] + e[2] * b[2];
        q = (mag_u(s) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        t = (s < 0) ? longint'(q) : -longint'(q);
        if (t > longint'(INT_MAX)) t = INT_MAX;
        if (t < -64'sd2147483648) t = INT_MIN;
        return int'(t);
    endfunction

    function automatic void predict_columns(t_view it);
        t_vec eye, rd, w, u, v;
        longint cs, sn;
        t_column col;
        cs = it.rot_cos;
        sn = it.rot_sin;
        for (int j = 0; j < 3; j++) eye[j] = it.eye[j];
        rd[0] = cs * it.dir[0] + sn * it.dir[2];
        rd[1] = longint'(it.dir[1]) <<< FRAC_BITS;
        rd[2] = cs * it.dir[2] - sn * it.dir[0];
        w = unit_vec(rd);
        u = unit_vec(cross_vec(up_vec, w));
        v = unit_vec(cross_vec(w, u));
        for (int k = 0; k < 4; k++) begin
            col.column_index = k[1:0];
            col.last_column  = (k == 3);
            if (k < 3) begin
                col.elem = '{int'(u[k]), int'(v[k]), int'(w[k]), 0};
            end else begin
                col.elem = '{translate_term(eye, u), translate_term(eye, v),
                             translate_term(eye, w), int'(ONE)};
            end
            column_q.push_back(col);
        end
    endfunction

    function automatic void push_typed(t_row r);
        t_column col;
        for (int k = 0; k < 4; k++) begin
            col.column_index = k[1:0];
            col.last_column  = (k == 3);
            for (int j = 0; j < 4; j++) col.elem[j] = r.cols[k][j];
            column_q.push_back(col);
        end
    endfunction

    // ---------------- stimulus helpers ----------------

    task automatic cfg_write(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        case (idx)
            REG_UP_X:  up_vec[0] = int'(data);
            REG_UP_Y:  up_vec[1] = int'(data);
            REG_UP_Z:  up_vec[2] = int'(data);
            REG_GUARD: guard_mag = data[GW-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Send one beat; valid stays high into a back-to-back beat
    task automatic send_view(t_view it, t_row r, bit use_typed);
        int gap;
        gap = $urandom_range(0, 13);
        if (($urandom_range(0, 3) == 0)) gap = 0;
        if (gap > 0) begin
            item_bus.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_bus.valid   = 1'b1;
        item_bus.eye_x   = it.eye[0];
        item_bus.eye_y   = it.eye[1];
        item_bus.eye_z   = it.eye[2];
        item_bus.dir_x   = it.dir[0];
        item_bus.dir_y   = it.dir[1];
        item_bus.dir_z   = it.dir[2];
        item_bus.rot_cos = it.rot_cos;
        item_bus.rot_sin = it.rot_sin;
        do @(posedge i_clk); while (!item_bus.ready);
        if (use_typed) push_typed(r);
        else predict_columns(it);
        @(negedge i_clk);
    endtask

    function automatic int rand_comp();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return $urandom_range(0, 131072) - 65536;
            2:       return ($urandom_range(0, 1)) ? INT_MAX : INT_MIN;
            3:       return $urandom_range(0, 1 << 24) - (1 << 23);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_view rand_view();
        t_view it;
        for (int j = 0; j < 3; j++) begin
            it.eye[j] = rand_comp();
            it.dir[j] = rand_comp();
        end
        // Occasionally a degenerate direction
        if ($urandom_range(0, 15) == 0) it.dir = '{0, 0, 0};
        if ($urandom_range(0, 9) == 0) begin
            it.rot_cos = 18'($urandom);
            it.rot_sin = 18'($urandom);
        end else begin
            it.rot_cos = 18'(int'($urandom_range(0, 131072)) - 65536);
            it.rot_sin = 18'(int'($urandom_range(0, 131072)) - 65536);
        end
        return it;
    endfunction

    task automatic wait_drained();
        item_bus.valid = 1'b0;
        while (column_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_random(int count);
        t_row dummy;
        dummy.typed = 0;
        repeat (count) send_view(rand_view(), dummy, 1'b0);
    endtask

    // ---------------- directed table ----------------

    t_row dir_rows [] = '{
        // identity view after reset
        '{'{'{0, 0, 0}, '{0, 0, 65536}, 18'sd65536, 18'sd0}, 1'b1,
          '{'{65536, 0, 0, 0}, '{0, 65536, 0, 0}, '{0, 0, 65536, 0}, '{0, 0, 0, 65536}}},
        // zero direction: guard magnitude, everything normalizes to zero
        '{'{'{0, 0, 0}, '{0, 0, 0}, 18'sd65536, 18'sd0}, 1'b1,
          '{'{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 65536}}},
        // looking along up: cross product vanishes
        '{'{'{0, 0, 0}, '{0, 1, 0}, 18'sd65536, 18'sd0}, 1'b1,
          '{'{0, 0, 0, 0}, '{0, 0, 65536, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 65536}}},
        '{'{'{INT_MAX, INT_MAX, INT_MAX}, '{0, 0, 65536}, 18'sd65536, 18'sd0}, 1'b0,
          '{default: '{default: 0}}},
        '{'{'{INT_MIN, INT_MIN, INT_MIN}, '{0, 0, -65536}, 18'sd65536, 18'sd0}, 1'b0,
          '{default: '{default: 0}}},
        '{'{'{INT_MIN, INT_MAX, INT_MIN}, '{INT_MIN, INT_MIN, INT_MIN},
            -18'sd65536, 18'sd65536}, 1'b0, '{default: '{default: 0}}},
        '{'{'{INT_MAX, INT_MIN, INT_MAX}, '{INT_MAX, INT_MAX, INT_MAX},
            18'sd65536, -18'sd65536}, 1'b0, '{default: '{default: 0}}},
        // cos/sin outside the unit range
        '{'{'{1, -1, 1}, '{65536, 0, 65536}, 18'sh20000, 18'sd131071}, 1'b0,
          '{default: '{default: 0}}},
        '{'{'{-1, 1, -1}, '{-65536, 7, 3}, 18'sd131071, 18'sh20000}, 1'b0,
          '{default: '{default: 0}}},
        '{'{'{32768, -32768, 32768}, '{1, 0, 0}, 18'sd0, 18'sd65536}, 1'b0,
          '{default: '{default: 0}}},
        '{'{'{0, 0, 0}, '{1, 1, 1}, 18'sd46341, 18'sd46341}, 1'b0,
          '{default: '{default: 0}}},
        '{'{'{100, 200, 300}, '{INT_MAX, 0, 0}, 18'sd0, 18'sd0}, 1'b0,
          '{default: '{default: 0}}},
        '{'{'{-5, 0, 5}, '{0, INT_MIN, 0}, 18'sd0, 18'sd0}, 1'b0,
          '{default: '{default: 0}}}
    };

    // ---------------- main sequence ----------------

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = REG_UP_X;
        i_cfg_data     = '0;
        item_bus.valid = 1'b0;
        item_bus.eye_x = '0;
        item_bus.eye_y = '0;
        item_bus.eye_z = '0;
        item_bus.dir_x = '0;
        item_bus.dir_y = '0;
        item_bus.dir_z = '0;
        item_bus.rot_cos = '0;
        item_bus.rot_sin = '0;
        up_vec    = '{0, 65536, 0};
        guard_mag = 7;
        errors    = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) send_view(dir_rows[i].view, dir_rows[i], dir_rows[i].typed);
        run_random(40);
        // Sender pauses until every column has come back
        wait_drained();

        cfg_write(REG_UP_X, INT_MIN);
        cfg_write(REG_UP_Y, INT_MAX);
        cfg_write(REG_UP_Z, INT_MIN);
        cfg_write(REG_GUARD, 32'd65536);
        run_random(38);
        wait_drained();

        cfg_write(REG_UP_X, 0);
        cfg_write(REG_UP_Y, 0);
        cfg_write(REG_UP_Z, 0);
        cfg_write(REG_GUARD, 32'd1);
        run_random(30);
        wait_drained();

        cfg_write(REG_UP_X, INT_MAX);
        cfg_write(REG_UP_Y, INT_MIN);
        cfg_write(REG_UP_Z, INT_MAX);
        cfg_write(REG_GUARD, 32'd0);
        cfg_write(REG_UNUSED, $urandom);
        run_random(38);
        wait_drained();

        cfg_write(REG_UP_X, $urandom);
        cfg_write(REG_UP_Y, $urandom);
        cfg_write(REG_UP_Z, $urandom);
        cfg_write(REG_GUARD, $urandom);
        run_random(38);
        wait_drained();

        cfg_write(REG_UP_X, 32'($urandom_range(0, 131072)) - 32'd65536);
        cfg_write(REG_UP_Y, 32'($urandom_range(0, 131072)) - 32'd65536);
        cfg_write(REG_UP_Z, 32'($urandom_range(0, 131072)) - 32'd65536);
        cfg_write(REG_GUARD, 32'($urandom_range(1, 65536)));
        run_random(38);
        wait_drained();

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // ---------------- column receiver and checker ----------------

    initial begin
        int gap;
        t_column exp_col;
        int act [4];
        col_bus.ready = 1'b0;
        beats_seen = 0;
        @(posedge i_rst_n);
        forever begin
            gap = $urandom_range(0, 13);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (beats_seen == 60) gap = HOLD_CYCLES;
            if (gap > 0) begin
                col_bus.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            col_bus.ready = 1'b1;
            do @(posedge i_clk); while (!col_bus.valid);
            beats_seen++;
            act = '{col_bus.elem_row0, col_bus.elem_row1, col_bus.elem_row2,
                    col_bus.elem_row3};
            if (column_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected column beat, index %0d", $time,
                         col_bus.column_index);
            end else begin
                exp_col = column_q.pop_front();
                if (col_bus.column_index !== exp_col.column_index) begin
                    errors++;
                    $display("%0t: column_index expected %0d actual %0d", $time,
                             exp_col.column_index, col_bus.column_index);
                end
                for (int j = 0; j < 4; j++) begin
                    if (act[j] !== exp_col.elem[j]) begin
                        errors++;
                        $display("%0t: col %0d row %0d expected %0d actual %0d", $time,
                                 exp_col.column_index, j, exp_col.elem[j], act[j]);
                    end
                end
                if (col_bus.last_column !== exp_col.last_column) begin
                    errors++;
                    $display("%0t: last_column expected %0b actual %0b", $time,
                             exp_col.last_column, col_bus.last_column);
                end
            end
            @(negedge i_clk);
        end
    end

    // ---------------- watchdog ----------------

    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((item_bus.valid && item_bus.ready) || (col_bus.valid && col_bus.ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
            if (idle >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

endmodule
